[sv/look_at_view_matrix_top_assert.svh]
// Assertion macros shared by the look-at checker.
`ifndef LOOK_AT_VIEW_MATRIX_TOP_ASSERT_SVH
`define LOOK_AT_VIEW_MATRIX_TOP_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define LAVM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define LAVM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/lavm_pkg.sv]
package lavm_pkg;

	// Fraction bits of a basis axis component.
	localparam int AXIS_FRAC = 30;

	typedef logic signed [31:0] axis_t;
	typedef logic signed [63:0] wide_t;

	// Control that travels with an item through the normalize unit.
	typedef struct packed {
		logic valid;
		logic ok;
	} norm_ctl_t;

	typedef logic [1:0] row_t;

	localparam row_t ROW_U = 2'd0;
	localparam row_t ROW_V = 2'd1;
	localparam row_t ROW_W = 2'd2;

	// Unit length in Q1.30, as a magnitude.
	localparam logic [30:0] ONE_AXIS = 31'(1) << AXIS_FRAC;

endpackage

[sv/look_at_view_matrix_top.sv]
// Channel  Handshake                  Payload
// input    start, busy                command, eye_x..z, aim_x..z, up_x..z
// result   result_valid (strobe)      row_index, axis_x..z, offset, degenerate, last
//
// An item is accepted at an edge where start is high and busy is low; busy then
// stays high while either bit of the shift register acc_q is set. This spacing
// lets the three result rows of each item share the one result port.
// Row 0 reaches the ports through the input, normalize, cross-product, up-axis
// and offset stages; rows 1 and 2 follow it back to back. Two normalize units
// (76 stages each, mostly the square root and the divider) are most of the depth.
// Reset clears the valid bits and the row sequencer; data registers are not reset.
// The receiver cannot stall; the pipeline never holds.
module look_at_view_matrix_top
	import lavm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               command,
	input  logic signed [31:0] eye_x,
	input  logic signed [31:0] eye_y,
	input  logic signed [31:0] eye_z,
	input  logic signed [31:0] aim_x,
	input  logic signed [31:0] aim_y,
	input  logic signed [31:0] aim_z,
	input  logic signed [31:0] up_x,
	input  logic signed [31:0] up_y,
	input  logic signed [31:0] up_z,
	output logic               result_valid,
	output row_t               row_index,
	output axis_t              axis_x,
	output axis_t              axis_y,
	output axis_t              axis_z,
	output logic signed [31:0] offset,
	output logic               degenerate,
	output logic               last
);

	localparam int SIDE_W = 192;
	localparam logic [63:0] ROUND_HALF = 64'd1 << (AXIS_FRAC - 1);
	localparam logic [33:0] SAT_POS = 34'h0_7FFF_FFFF;
	localparam logic [33:0] SAT_NEG = 34'h0_8000_0000;

	logic       accept;
	logic [1:0] acc_q;

	logic               valid_s1, cmd_s1;
	logic signed [31:0] eye_s1 [3];
	logic signed [31:0] aim_s1 [3];
	logic signed [31:0] up_s1  [3];

	logic               valid_s2;
	wide_t              dir_s2 [3];
	logic signed [31:0] eye_s2 [3];
	logic signed [31:0] up_s2  [3];

	norm_ctl_t         n1_ctl_in, n1_ctl;
	axis_t             w_n1 [3];
	logic [SIDE_W-1:0] n1_side;

	norm_ctl_t          ctl_c1, ctl_c2;
	wide_t              cp_c1 [6];
	wide_t              cr_c2 [3];
	axis_t              w_c1 [3];
	axis_t              w_c2 [3];
	logic signed [31:0] eye_c1 [3];
	logic signed [31:0] eye_c2 [3];

	norm_ctl_t         n2_ctl;
	axis_t             u_n2 [3];
	logic [SIDE_W-1:0] n2_side;

	norm_ctl_t          ctl_v1, ctl_v2, ctl_v3, ctl_v4;
	wide_t              vp_v1 [6];
	wide_t              vr_v2 [3];
	logic [62:0]        vm_v3 [3];
	logic [2:0]         vneg_v3;
	axis_t              v_v4 [3];
	axis_t              u_v1 [3];
	axis_t              u_v2 [3];
	axis_t              u_v3 [3];
	axis_t              u_v4 [3];
	axis_t              w_v1 [3];
	axis_t              w_v2 [3];
	axis_t              w_v3 [3];
	axis_t              w_v4 [3];
	logic signed [31:0] eye_v1 [3];
	logic signed [31:0] eye_v2 [3];
	logic signed [31:0] eye_v3 [3];
	logic signed [31:0] eye_v4 [3];

	norm_ctl_t          ctl_o1, ctl_o2, ctl_o3, ctl_o4;
	wide_t              op_o1 [3][3];
	wide_t              d_o2  [3];
	logic [63:0]        dm_o3 [3];
	logic [2:0]         dpos_o3;
	logic signed [31:0] off_o4 [3];
	axis_t              ax_o1 [3][3];
	axis_t              ax_o2 [3][3];
	axis_t              ax_o3 [3][3];
	axis_t              ax_o4 [3][3];
	logic signed [31:0] off_nx [3];
	axis_t              v_nx [3];

	// Row sequencer: ROW_U means no row pending, otherwise the next row to send.
	row_t               phase_q;
	axis_t              hold_ax_q  [2][3];
	logic signed [31:0] hold_off_q [2];
	logic               hold_deg_q;

	// Input transfer and spacing of items.
	assign accept = start && !busy;
	assign busy   = |acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else begin
			acc_q <= {acc_q[0], accept};
		end
	end

	// Valid bits of the stages outside the normalize units.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			ctl_c1   <= '0;
			ctl_c2   <= '0;
			ctl_v1   <= '0;
			ctl_v2   <= '0;
			ctl_v3   <= '0;
			ctl_v4   <= '0;
			ctl_o1   <= '0;
			ctl_o2   <= '0;
			ctl_o3   <= '0;
			ctl_o4   <= '0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			ctl_c1   <= n1_ctl;
			ctl_c2   <= ctl_c1;
			ctl_v1   <= n2_ctl;
			ctl_v2   <= ctl_v1;
			ctl_v3   <= ctl_v2;
			ctl_v4   <= ctl_v3;
			ctl_o1   <= ctl_v4;
			ctl_o2   <= ctl_o1;
			ctl_o3   <= ctl_o2;
			ctl_o4   <= ctl_o3;
		end
	end

	// Input capture and view direction.
	always_ff @(posedge clk) begin
		cmd_s1    <= command;
		eye_s1[0] <= eye_x;
		eye_s1[1] <= eye_y;
		eye_s1[2] <= eye_z;
		aim_s1[0] <= aim_x;
		aim_s1[1] <= aim_y;
		aim_s1[2] <= aim_z;
		up_s1[0]  <= up_x;
		up_s1[1]  <= up_y;
		up_s1[2]  <= up_z;
		for (int i = 0; i < 3; i++) begin
			if (cmd_s1) begin
				dir_s2[i] <= wide_t'(33'(aim_s1[i]) - 33'(eye_s1[i]));
			end else begin
				dir_s2[i] <= wide_t'(aim_s1[i]);
			end
			eye_s2[i] <= eye_s1[i];
			up_s2[i]  <= up_s1[i];
		end
	end

	// Forward axis w.
	assign n1_ctl_in = '{valid: valid_s2, ok: 1'b1};

	lavm_norm #(
		.SIDE_W (SIDE_W)
	) u_norm_w (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_in   (n1_ctl_in),
		.vec_in   (dir_s2),
		.side_in  ({eye_s2[0], eye_s2[1], eye_s2[2], up_s2[0], up_s2[1], up_s2[2]}),
		.ctl_out  (n1_ctl),
		.q_out    (w_n1),
		.side_out (n1_side)
	);

	// Exact cross(w, up): products, then differences.
	always_ff @(posedge clk) begin
		logic signed [31:0] up_n1 [3];
		for (int i = 0; i < 3; i++) begin
			up_n1[i]  = n1_side[95 - 32 * i -: 32];
			eye_c1[i] <= n1_side[191 - 32 * i -: 32];
			w_c1[i]   <= w_n1[i];
			eye_c2[i] <= eye_c1[i];
			w_c2[i]   <= w_c1[i];
		end
		cp_c1[0] <= wide_t'(w_n1[1]) * wide_t'(up_n1[2]);
		cp_c1[1] <= wide_t'(w_n1[2]) * wide_t'(up_n1[1]);
		cp_c1[2] <= wide_t'(w_n1[2]) * wide_t'(up_n1[0]);
		cp_c1[3] <= wide_t'(w_n1[0]) * wide_t'(up_n1[2]);
		cp_c1[4] <= wide_t'(w_n1[0]) * wide_t'(up_n1[1]);
		cp_c1[5] <= wide_t'(w_n1[1]) * wide_t'(up_n1[0]);
		for (int i = 0; i < 3; i++) begin
			cr_c2[i] <= cp_c1[2 * i] - cp_c1[2 * i + 1];
		end
	end

	// Right axis u.
	lavm_norm #(
		.SIDE_W (SIDE_W)
	) u_norm_u (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_in   (ctl_c2),
		.vec_in   (cr_c2),
		.side_in  ({w_c2[0], w_c2[1], w_c2[2], eye_c2[0], eye_c2[1], eye_c2[2]}),
		.ctl_out  (n2_ctl),
		.q_out    (u_n2),
		.side_out (n2_side)
	);

	// Round and clamp cross(w, u) to Q1.30.
	always_comb begin
		logic [32:0] m;
		for (int i = 0; i < 3; i++) begin
			m = 33'(vm_v3[i] >> AXIS_FRAC);
			if (m > 33'(ONE_AXIS)) begin
				m = 33'(ONE_AXIS);
			end
			v_nx[i] = vneg_v3[i] ? -axis_t'(m[31:0]) : axis_t'(m[31:0]);
		end
	end

	// Up axis v = cross(w, u).
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			w_v1[i]   <= n2_side[191 - 32 * i -: 32];
			eye_v1[i] <= n2_side[95 - 32 * i -: 32];
			u_v1[i]   <= u_n2[i];
			w_v2[i]   <= w_v1[i];
			w_v3[i]   <= w_v2[i];
			w_v4[i]   <= w_v3[i];
			u_v2[i]   <= u_v1[i];
			u_v3[i]   <= u_v2[i];
			u_v4[i]   <= u_v3[i];
			eye_v2[i] <= eye_v1[i];
			eye_v3[i] <= eye_v2[i];
			eye_v4[i] <= eye_v3[i];
		end
		vp_v1[0] <= wide_t'(axis_t'(n2_side[159:128])) * wide_t'(u_n2[2]);
		vp_v1[1] <= wide_t'(axis_t'(n2_side[127:96])) * wide_t'(u_n2[1]);
		vp_v1[2] <= wide_t'(axis_t'(n2_side[127:96])) * wide_t'(u_n2[0]);
		vp_v1[3] <= wide_t'(axis_t'(n2_side[191:160])) * wide_t'(u_n2[2]);
		vp_v1[4] <= wide_t'(axis_t'(n2_side[191:160])) * wide_t'(u_n2[1]);
		vp_v1[5] <= wide_t'(axis_t'(n2_side[159:128])) * wide_t'(u_n2[0]);
		for (int i = 0; i < 3; i++) begin
			vr_v2[i]   <= vp_v1[2 * i] - vp_v1[2 * i + 1];
			vneg_v3[i] <= vr_v2[i][63];
			vm_v3[i]   <= (vr_v2[i][63] ? 63'(-vr_v2[i]) : vr_v2[i][62:0]) +
				63'(ROUND_HALF);
			v_v4[i]    <= v_nx[i];
		end
	end

	// Saturate the rounded offsets.
	always_comb begin
		logic [33:0] m;
		for (int k = 0; k < 3; k++) begin
			m = dm_o3[k][63:AXIS_FRAC];
			if (dpos_o3[k]) begin
				off_nx[k] = (m > SAT_NEG) ? $signed(SAT_NEG[31:0]) : $signed(32'(-m));
			end else begin
				off_nx[k] = (m > SAT_POS) ? $signed(SAT_POS[31:0]) : $signed(m[31:0]);
			end
		end
	end

	// Offsets: minus the dot of each axis with the eye.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			ax_o1[ROW_U][i] <= u_v4[i];
			ax_o1[ROW_V][i] <= v_v4[i];
			ax_o1[ROW_W][i] <= w_v4[i];
			op_o1[ROW_U][i] <= wide_t'(u_v4[i]) * wide_t'(eye_v4[i]);
			op_o1[ROW_V][i] <= wide_t'(v_v4[i]) * wide_t'(eye_v4[i]);
			op_o1[ROW_W][i] <= wide_t'(w_v4[i]) * wide_t'(eye_v4[i]);
		end
		ax_o2 <= ax_o1;
		ax_o3 <= ax_o2;
		ax_o4 <= ax_o3;
		for (int k = 0; k < 3; k++) begin
			d_o2[k]    <= op_o1[k][0] + op_o1[k][1] + op_o1[k][2];
			dpos_o3[k] <= !d_o2[k][63] && (d_o2[k] != '0);
			dm_o3[k]   <= (d_o2[k][63] ? 64'(-d_o2[k]) : 64'(d_o2[k])) + ROUND_HALF;
			off_o4[k]  <= off_nx[k];
		end
	end

	// Row sequencer and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
			phase_q      <= ROW_U;
		end else if (phase_q != ROW_U) begin
			result_valid <= 1'b1;
			phase_q      <= (phase_q == ROW_W) ? ROW_U : ROW_W;
		end else if (ctl_o4.valid) begin
			result_valid <= 1'b1;
			phase_q      <= ROW_V;
		end else begin
			result_valid <= 1'b0;
		end
	end

	// Result rows; a degenerate item sends zeros.
	always_ff @(posedge clk) begin
		if (phase_q != ROW_U) begin
			row_index  <= phase_q;
			axis_x     <= hold_ax_q[phase_q == ROW_W][0];
			axis_y     <= hold_ax_q[phase_q == ROW_W][1];
			axis_z     <= hold_ax_q[phase_q == ROW_W][2];
			offset     <= hold_off_q[phase_q == ROW_W];
			degenerate <= hold_deg_q;
			last       <= (phase_q == ROW_W);
		end else if (ctl_o4.valid) begin
			row_index  <= ROW_U;
			axis_x     <= ctl_o4.ok ? ax_o4[ROW_U][0] : '0;
			axis_y     <= ctl_o4.ok ? ax_o4[ROW_U][1] : '0;
			axis_z     <= ctl_o4.ok ? ax_o4[ROW_U][2] : '0;
			offset     <= ctl_o4.ok ? off_o4[ROW_U] : '0;
			degenerate <= !ctl_o4.ok;
			last       <= 1'b0;
			hold_deg_q <= !ctl_o4.ok;
			for (int k = 0; k < 2; k++) begin
				hold_off_q[k] <= ctl_o4.ok ? off_o4[k + 1] : '0;
				for (int i = 0; i < 3; i++) begin
					hold_ax_q[k][i] <= ctl_o4.ok ? ax_o4[k + 1][i] : '0;
				end
			end
		end
	end

endmodule

[sv/lavm_norm.sv]
module lavm_norm
	import lavm_pkg::*;
#(
	parameter int SIDE_W = 192
) (
	input  logic              clk,
	input  logic              arst_n,
	input  norm_ctl_t         ctl_in,
	input  wide_t             vec_in [3],
	input  logic [SIDE_W-1:0] side_in,
	output norm_ctl_t         ctl_out,
	output axis_t             q_out [3],
	output logic [SIDE_W-1:0] side_out
);

	localparam int LZC_STEPS  = 6;
	localparam int SQRT_STEPS = 32;
	localparam int QUO_BITS   = 31;
	// Leading-zero count at which the scaled magnitude needs no shift beyond
	// the extra rounding bit.
	localparam logic [5:0] PIVOT = 6'(63 - AXIS_FRAC);

	typedef struct packed {
		logic [2:0]        neg;
		logic [2:0][62:0]  mag;
		logic [SIDE_W-1:0] side;
	} front_t;

	typedef struct packed {
		logic [2:0]        neg;
		logic [2:0][30:0]  mr;
		logic [SIDE_W-1:0] side;
	} root_t;

	typedef struct packed {
		logic [2:0]        neg;
		logic [31:0]       r;
		logic [2:0][61:0]  rem;
		logic [2:0][30:0]  quo;
		logic [SIDE_W-1:0] side;
	} quot_t;

	// Leading-zero search stages; index 0 is the magnitude stage.
	norm_ctl_t   ctl_l [LZC_STEPS+1];
	front_t      car_l [LZC_STEPS+1];
	logic [63:0] lz_x  [LZC_STEPS+1];
	logic [5:0]  lz_n  [LZC_STEPS+1];

	// Shift, round and square stages.
	norm_ctl_t         ctl_sh, ctl_rd, ctl_sq;
	logic [2:0]        neg_sh, neg_rd;
	logic [SIDE_W-1:0] side_sh, side_rd;
	logic [31:0]       t_sh  [3];
	logic [30:0]       mr_rd [3];
	logic [61:0]       sq_sq [3];
	root_t             car_sq;

	// Square root stages; index 0 holds the sum of squares times four.
	norm_ctl_t   ctl_r [SQRT_STEPS+1];
	root_t       car_r [SQRT_STEPS+1];
	logic [63:0] rt_n  [SQRT_STEPS+1];
	logic [63:0] rt_r  [SQRT_STEPS+1];

	// Division stages; index 0 holds the rounded dividends.
	norm_ctl_t ctl_d [QUO_BITS+1];
	quot_t     car_d [QUO_BITS+1];

	logic [62:0] mag_in [3];
	logic [62:0] mx_in;
	logic [63:0] lz_x_nx [1:LZC_STEPS];
	logic [5:0]  lz_n_nx [1:LZC_STEPS];
	logic [31:0] t_nx    [3];
	logic [61:0] sum_sq;
	logic [63:0] rt_n_nx [1:SQRT_STEPS];
	logic [63:0] rt_r_nx [1:SQRT_STEPS];
	quot_t       car_d_nx [1:QUO_BITS];
	axis_t       q_nx    [3];

	// Magnitudes and their maximum.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_in[i] = vec_in[i][63] ? 63'(-vec_in[i]) : vec_in[i][62:0];
		end
		mx_in = mag_in[0];
		if (mag_in[1] > mx_in) begin
			mx_in = mag_in[1];
		end
		if (mag_in[2] > mx_in) begin
			mx_in = mag_in[2];
		end
	end

	// Binary leading-zero search, halving the window each stage.
	always_comb begin
		for (int k = 1; k <= LZC_STEPS; k++) begin
			if ((lz_x[k-1] >> (64 - (32 >> (k - 1)))) == 64'd0) begin
				lz_x_nx[k] = lz_x[k-1] << (32 >> (k - 1));
				lz_n_nx[k] = lz_n[k-1] + 6'(32 >> (k - 1));
			end else begin
				lz_x_nx[k] = lz_x[k-1];
				lz_n_nx[k] = lz_n[k-1];
			end
		end
	end

	// Scale so the largest magnitude sits just below 2^30, keeping one extra bit.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (lz_n[LZC_STEPS] <= PIVOT) begin
				t_nx[i] = 32'(car_l[LZC_STEPS].mag[i] >> (PIVOT - lz_n[LZC_STEPS]));
			end else begin
				t_nx[i] = 32'(64'(car_l[LZC_STEPS].mag[i]) << (lz_n[LZC_STEPS] - PIVOT));
			end
		end
	end

	assign sum_sq = sq_sq[0] + sq_sq[1] + sq_sq[2];

	// Digit-by-digit square root, one result bit per stage.
	always_comb begin
		logic [63:0] bit_v;
		logic [63:0] trial;
		for (int k = 1; k <= SQRT_STEPS; k++) begin
			bit_v = 64'd1 << (62 - 2 * (k - 1));
			trial = rt_r[k-1] + bit_v;
			if (rt_n[k-1] >= trial) begin
				rt_n_nx[k] = rt_n[k-1] - trial;
				rt_r_nx[k] = (rt_r[k-1] >> 1) + bit_v;
			end else begin
				rt_n_nx[k] = rt_n[k-1];
				rt_r_nx[k] = rt_r[k-1] >> 1;
			end
		end
	end

	// Restoring division, one quotient bit per stage for all three lanes.
	always_comb begin
		logic [62:0] dvs;
		for (int j = 1; j <= QUO_BITS; j++) begin
			car_d_nx[j] = car_d[j-1];
			dvs = 63'(car_d[j-1].r) << (QUO_BITS - j);
			for (int i = 0; i < 3; i++) begin
				if ({1'b0, car_d[j-1].rem[i]} >= dvs) begin
					car_d_nx[j].rem[i] = car_d[j-1].rem[i] - dvs[61:0];
					car_d_nx[j].quo[i] = {car_d[j-1].quo[i][QUO_BITS-2:0], 1'b1};
				end else begin
					car_d_nx[j].quo[i] = {car_d[j-1].quo[i][QUO_BITS-2:0], 1'b0};
				end
			end
		end
	end

	// Clamp to unit length and restore the sign; an item that failed gives zeros.
	always_comb begin
		logic [30:0] tm;
		for (int i = 0; i < 3; i++) begin
			tm = (car_d[QUO_BITS].quo[i] > ONE_AXIS) ? ONE_AXIS : car_d[QUO_BITS].quo[i];
			if (!ctl_d[QUO_BITS].ok) begin
				q_nx[i] = '0;
			end else if (car_d[QUO_BITS].neg[i]) begin
				q_nx[i] = -axis_t'(32'(tm));
			end else begin
				q_nx[i] = axis_t'(32'(tm));
			end
		end
	end

	// Valid bits of every stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= LZC_STEPS; k++) begin
				ctl_l[k] <= '0;
			end
			ctl_sh <= '0;
			ctl_rd <= '0;
			ctl_sq <= '0;
			for (int k = 0; k <= SQRT_STEPS; k++) begin
				ctl_r[k] <= '0;
			end
			for (int k = 0; k <= QUO_BITS; k++) begin
				ctl_d[k] <= '0;
			end
			ctl_out <= '0;
		end else begin
			ctl_l[0] <= '{valid: ctl_in.valid, ok: ctl_in.ok && (mx_in != '0)};
			for (int k = 1; k <= LZC_STEPS; k++) begin
				ctl_l[k] <= ctl_l[k-1];
			end
			ctl_sh   <= ctl_l[LZC_STEPS];
			ctl_rd   <= ctl_sh;
			ctl_sq   <= ctl_rd;
			ctl_r[0] <= ctl_sq;
			for (int k = 1; k <= SQRT_STEPS; k++) begin
				ctl_r[k] <= ctl_r[k-1];
			end
			ctl_d[0] <= ctl_r[SQRT_STEPS];
			for (int k = 1; k <= QUO_BITS; k++) begin
				ctl_d[k] <= ctl_d[k-1];
			end
			ctl_out <= ctl_d[QUO_BITS];
		end
	end

	// Data of every stage.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			car_l[0].mag[i] <= mag_in[i];
			car_l[0].neg[i] <= vec_in[i][63];
		end
		car_l[0].side <= side_in;
		lz_x[0]       <= {1'b0, mx_in};
		lz_n[0]       <= '0;
		for (int k = 1; k <= LZC_STEPS; k++) begin
			car_l[k] <= car_l[k-1];
			lz_x[k]  <= lz_x_nx[k];
			lz_n[k]  <= lz_n_nx[k];
		end

		neg_sh  <= car_l[LZC_STEPS].neg;
		side_sh <= car_l[LZC_STEPS].side;
		neg_rd  <= neg_sh;
		side_rd <= side_sh;
		for (int i = 0; i < 3; i++) begin
			t_sh[i]       <= t_nx[i];
			mr_rd[i]      <= 31'((33'(t_sh[i]) + 33'd1) >> 1);
			sq_sq[i]      <= 62'(mr_rd[i]) * 62'(mr_rd[i]);
			car_sq.mr[i]  <= mr_rd[i];
		end
		car_sq.neg  <= neg_rd;
		car_sq.side <= side_rd;

		car_r[0] <= car_sq;
		rt_n[0]  <= {sum_sq, 2'b00};
		rt_r[0]  <= '0;
		for (int k = 1; k <= SQRT_STEPS; k++) begin
			car_r[k] <= car_r[k-1];
			rt_n[k]  <= rt_n_nx[k];
			rt_r[k]  <= rt_r_nx[k];
		end

		car_d[0].neg  <= car_r[SQRT_STEPS].neg;
		car_d[0].side <= car_r[SQRT_STEPS].side;
		car_d[0].r    <= rt_r[SQRT_STEPS][31:0];
		for (int i = 0; i < 3; i++) begin
			car_d[0].rem[i] <= {car_r[SQRT_STEPS].mr[i], 31'd0} +
				62'(rt_r[SQRT_STEPS][31:1]);
			car_d[0].quo[i] <= '0;
		end
		for (int k = 1; k <= QUO_BITS; k++) begin
			car_d[k] <= car_d_nx[k];
		end

		for (int i = 0; i < 3; i++) begin
			q_out[i] <= q_nx[i];
		end
		side_out <= car_d[QUO_BITS].side;
	end

endmodule

[sv/lavm_checker.sv]
`include "look_at_view_matrix_top_assert.svh"

module lavm_checker
	import lavm_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               result_valid,
	input row_t               row_index,
	input axis_t              axis_x,
	input axis_t              axis_y,
	input axis_t              axis_z,
	input logic signed [31:0] offset,
	input logic               degenerate,
	input logic               last
);

	// An accepted item blocks the next cycle.
	`LAVM_ASSERT_NEXT(a_busy_after_transfer, start && !busy, busy, "busy low after transfer")

	// Last marks the w row and nothing else.
	`LAVM_ASSERT_NOW(a_last_on_w, result_valid, last == (row_index == ROW_W), "last misplaced")

	// Row u is followed directly by row v.
	`LAVM_ASSERT_NEXT(a_u_then_v, result_valid && row_index == ROW_U,
		result_valid && row_index == ROW_V, "row v missing after row u")

	// Row v is followed directly by row w of the same item.
	`LAVM_ASSERT_NEXT(a_v_then_w, result_valid && row_index == ROW_V,
		result_valid && row_index == ROW_W && degenerate == $past(degenerate),
		"row w missing after row v")

	// A degenerate row carries zeros.
	`LAVM_ASSERT_NOW(a_degenerate_zero, result_valid && degenerate,
		axis_x == 0 && axis_y == 0 && axis_z == 0 && offset == 0,
		"degenerate row not zero")

endmodule

bind look_at_view_matrix_top lavm_checker u_lavm_checker (.*);

[tb/sv/look_at_view_matrix_top_test.sv]
`timescale 1ns / 1ps

module look_at_view_matrix_top_test;
	import lavm_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 200;
	localparam logic CMD_DIRECTION = 1'b0;
	localparam logic CMD_TARGET = 1'b1;

	typedef longint vec3_t [3];

	// One look-at request as the sender sees it.
	typedef struct {
		logic cmd;
		logic signed [31:0] eye [3];
		logic signed [31:0] aim [3];
		logic signed [31:0] up [3];
	} view_req_t;

	// One basis row as the block should emit it.
	typedef struct {
		row_t row;
		logic [31:0] ax;
		logic [31:0] ay;
		logic [31:0] az;
		logic [31:0] off;
		logic degen;
		logic lst;
	} basis_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic command = 1'b0;
	logic signed [31:0] eye_x = '0, eye_y = '0, eye_z = '0;
	logic signed [31:0] aim_x = '0, aim_y = '0, aim_z = '0;
	logic signed [31:0] up_x = '0, up_y = '0, up_z = '0;
	logic result_valid;
	row_t row_index;
	axis_t axis_x, axis_y, axis_z;
	logic signed [31:0] offset;
	logic degenerate;
	logic last;

	basis_row_t basis_rows_due [$];
	int mismatch_count = 0;
	int requests_sent = 0;
	int rows_checked = 0;
	int degenerate_rows = 0;
	int idle_pct = 0;
	int quiet_cycles = 0;

	look_at_view_matrix_top i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .command(command),
		.eye_x(eye_x), .eye_y(eye_y), .eye_z(eye_z),
		.aim_x(aim_x), .aim_y(aim_y), .aim_z(aim_z),
		.up_x(up_x), .up_y(up_y), .up_z(up_z),
		.result_valid(result_valid), .row_index(row_index),
		.axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z),
		.offset(offset), .degenerate(degenerate), .last(last)
	);

	always #5 clk = ~clk;

	// Integer square root, floor.
	function automatic logic [63:0] int_sqrt(logic [63:0] n);
		logic [63:0] res = '0;
		logic [63:0] b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] magnitude(longint x);
		return (x < 0) ? 64'(-x) : 64'(x);
	endfunction

	// Divide by 2^30 with rounding to nearest, ties away from zero.
	function automatic longint round_q30(longint x);
		logic [63:0] m;
		m = (magnitude(x) + (64'd1 << (AXIS_FRAC - 1))) >> AXIS_FRAC;
		return (x < 0) ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint clamp_unit(longint x);
		if (x > (longint'(1) << AXIS_FRAC)) return longint'(1) << AXIS_FRAC;
		if (x < -(longint'(1) << AXIS_FRAC)) return -(longint'(1) << AXIS_FRAC);
		return x;
	endfunction

	// Scale to a fixed magnitude window, then divide by the length. Zero vector fails.
	function automatic bit unit_vector(input vec3_t c, output vec3_t q);
		logic [63:0] m [3];
		bit neg [3];
		logic [63:0] mx = '0;
		logic [63:0] s = '0;
		logic [63:0] r, t;
		int sh = 0;
		for (int i = 0; i < 3; i++) begin
			q[i] = 0;
			m[i] = magnitude(c[i]);
			neg[i] = c[i] < 0;
			if (m[i] > mx) mx = m[i];
		end
		if (mx == 0) return 1'b0;
		while (mx >= (64'd1 << 30)) begin
			mx = mx >> 1;
			sh++;
		end
		while (mx < (64'd1 << 29)) begin
			mx = mx << 1;
			sh--;
		end
		for (int i = 0; i < 3; i++) begin
			if (sh > 0) m[i] = (m[i] + (64'd1 << (sh - 1))) >> sh;
			else if (sh < 0) m[i] = m[i] << (-sh);
			s += m[i] * m[i];
		end
		r = int_sqrt(s << 2);
		for (int i = 0; i < 3; i++) begin
			t = ((m[i] << 31) + (r >> 1)) / r;
			if (t > (64'd1 << AXIS_FRAC)) t = 64'd1 << AXIS_FRAC;
			q[i] = neg[i] ? -longint'(t) : longint'(t);
		end
		return 1'b1;
	endfunction

	function automatic void cross_exact(input vec3_t a, input vec3_t b, output vec3_t o);
		o[0] = a[1] * b[2] - a[2] * b[1];
		o[1] = a[2] * b[0] - a[0] * b[2];
		o[2] = a[0] * b[1] - a[1] * b[0];
	endfunction

	// Work out the three basis rows for one request and queue them.
	function automatic void predict_basis_rows(view_req_t rq);
		vec3_t eye, dirv, up, cr, vr;
		vec3_t basis [3];
		bit ok;
		longint d, o;
		basis_row_t br;
		for (int i = 0; i < 3; i++) begin
			eye[i] = longint'(rq.eye[i]);
			up[i] = longint'(rq.up[i]);
			dirv[i] = (rq.cmd == CMD_TARGET) ? longint'(rq.aim[i]) - eye[i]
				: longint'(rq.aim[i]);
		end
		ok = unit_vector(dirv, basis[ROW_W]);
		if (ok) begin
			cross_exact(basis[ROW_W], up, cr);
			ok = unit_vector(cr, basis[ROW_U]);
		end
		if (ok) begin
			cross_exact(basis[ROW_W], basis[ROW_U], vr);
			for (int i = 0; i < 3; i++) basis[ROW_V][i] = clamp_unit(round_q30(vr[i]));
		end
		for (int k = 0; k < 3; k++) begin
			br.row = row_t'(k);
			br.lst = (k == 2);
			br.degen = !ok;
			if (ok) begin
				br.ax = basis[k][0][31:0];
				br.ay = basis[k][1][31:0];
				br.az = basis[k][2][31:0];
				d = basis[k][0] * eye[0] + basis[k][1] * eye[1] + basis[k][2] * eye[2];
				o = round_q30(-d);
				if (o > 64'sd2147483647) o = 64'sd2147483647;
				if (o < -64'sd2147483648) o = -64'sd2147483648;
				br.off = o[31:0];
			end else begin
				br.ax = '0;
				br.ay = '0;
				br.az = '0;
				br.off = '0;
			end
			basis_rows_due.push_back(br);
		end
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: row %0d %s got %h expected %h", $realtime, row_index, what, got, want);
		mismatch_count++;
	endtask

	// Present one request, hold it until the transfer, then maybe pause.
	task automatic send_request(view_req_t rq);
		command <= rq.cmd;
		eye_x <= rq.eye[0];
		eye_y <= rq.eye[1];
		eye_z <= rq.eye[2];
		aim_x <= rq.aim[0];
		aim_y <= rq.aim[1];
		aim_z <= rq.aim[2];
		up_x <= rq.up[0];
		up_y <= rq.up[1];
		up_z <= rq.up[2];
		start <= 1'b1;
		do @(posedge clk); while (busy);
		predict_basis_rows(rq);
		requests_sent++;
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
			3: return 32'(int'($urandom_range(0, 64)) - 32) <<< 16;
			default: return $urandom();
		endcase
	endfunction

	function automatic view_req_t random_request();
		view_req_t rq;
		int k;
		rq.cmd = 1'($urandom_range(0, 1));
		for (int i = 0; i < 3; i++) begin
			rq.eye[i] = pick_value();
			rq.aim[i] = pick_value();
			rq.up[i] = pick_value();
		end
		// Some requests are made degenerate on purpose.
		case ($urandom_range(0, 11))
			0: begin
				k = int'($urandom_range(1, 7)) - 4;
				for (int i = 0; i < 3; i++) begin
					rq.aim[i] = 32'(int'($urandom_range(0, 4000)) - 2000);
					rq.up[i] = rq.aim[i] * k;
				end
				rq.cmd = CMD_DIRECTION;
			end
			1: begin
				for (int i = 0; i < 3; i++) rq.aim[i] = rq.eye[i];
				rq.cmd = CMD_TARGET;
			end
			2: for (int i = 0; i < 3; i++) rq.up[i] = '0;
			default: ;
		endcase
		return rq;
	endfunction

	function automatic view_req_t make_request(logic cmd, int ex, int ey, int ez,
		int ax, int ay, int az, int ux, int uy, int uz);
		view_req_t rq;
		rq.cmd = cmd;
		rq.eye = '{ex, ey, ez};
		rq.aim = '{ax, ay, az};
		rq.up = '{ux, uy, uz};
		return rq;
	endfunction

	// Field extremes and both commands.
	task automatic test_extremes();
		int mn, mx;
		mn = 32'sh8000_0000;
		mx = 32'sh7fff_ffff;
		send_request(make_request(CMD_DIRECTION, 0, 0, 0, 0, 0, -65536, 0, 65536, 0));
		send_request(make_request(CMD_TARGET, 65536, 131072, 196608, 0, 0, 0, 0, 65536, 0));
		send_request(make_request(CMD_DIRECTION, mx, mx, mx, mn, mn, mn, mx, 0, 0));
		send_request(make_request(CMD_DIRECTION, mn, mn, mn, mx, mx, mx, 0, mn, mx));
		send_request(make_request(CMD_TARGET, mn, mn, mn, mx, mx, mx, mx, mn, 1));
		send_request(make_request(CMD_TARGET, mx, mn, mx, mn, mx, mn, 1, 0, 0));
		send_request(make_request(CMD_DIRECTION, mx, mn, 0, 1, 0, 0, 0, 1, 0));
		send_request(make_request(CMD_DIRECTION, -1, -1, -1, 1, 1, 1, 1, -1, 0));
		send_request(make_request(CMD_TARGET, 0, 0, mn, 0, 0, mx, mx, mx, 0));
		send_request(make_request(CMD_DIRECTION, mn, mx, mn, 1, mx, mn, mn, 1, -1));
		send_request(make_request(CMD_DIRECTION, mx, mx, mx, 3, -5, 7, mn, mn, mx));
	endtask

	// Zero direction, zero up, parallel and antiparallel up, target at the eye.
	task automatic test_degenerate();
		send_request(make_request(CMD_DIRECTION, 100, 200, 300, 0, 0, 0, 0, 65536, 0));
		send_request(make_request(CMD_DIRECTION, 100, 200, 300, 0, 0, 65536, 0, 0, 0));
		send_request(make_request(CMD_DIRECTION, 5, 6, 7, 0, 65536, 0, 0, 131072, 0));
		send_request(make_request(CMD_DIRECTION, 5, 6, 7, 3, -4, 5, -6, 8, -10));
		send_request(make_request(CMD_TARGET, 70000, -80000, 9, 70000, -80000, 9, 1, 2, 3));
		send_request(make_request(CMD_TARGET, 0, 0, 0, 2, 4, 6, 1, 2, 3));
		send_request(make_request(CMD_TARGET, 32'sh8000_0000, 0, 0, 32'sh8000_0000,
			0, 0, 0, 65536, 0));
	endtask

	task automatic test_random(int count, int pct);
		idle_pct = pct;
		repeat (count) send_request(random_request());
	endtask

	// Compare each row transfer with the oldest expectation.
	always @(posedge clk) begin
		basis_row_t want;
		if (arst_n && result_valid) begin
			rows_checked++;
			if (basis_rows_due.size() == 0) begin
				$display("%0t: unexpected row %0d", $realtime, row_index);
				mismatch_count++;
			end else begin
				want = basis_rows_due.pop_front();
				if (degenerate) degenerate_rows++;
				if (row_index !== want.row) report_mismatch("row_index", 32'(row_index), 32'(want.row));
				if (axis_x !== want.ax) report_mismatch("axis_x", axis_x, want.ax);
				if (axis_y !== want.ay) report_mismatch("axis_y", axis_y, want.ay);
				if (axis_z !== want.az) report_mismatch("axis_z", axis_z, want.az);
				if (offset !== want.off) report_mismatch("offset", offset, want.off);
				if (degenerate !== want.degen)
					report_mismatch("degenerate", 32'(degenerate), 32'(want.degen));
				if (last !== want.lst) report_mismatch("last", 32'(last), 32'(want.lst));
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((start && !busy) || result_valid) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_pct = 27;
		test_extremes();
		test_degenerate();
		test_random(150, 27);
		test_random(150, 71);
		test_random(152, 0);
		start <= 1'b0;
		while (basis_rows_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d look-at requests, checked %0d basis rows (%0d degenerate).",
			requests_sent, rows_checked, degenerate_rows);
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
